// ===== hdl/button_click_pattern_classifier_core_defines.svh =====
// assertion macros shared by the checker
`ifndef BUTTON_CLICK_PATTERN_CLASSIFIER_CORE_DEFINES_SVH
`define BUTTON_CLICK_PATTERN_CLASSIFIER_CORE_DEFINES_SVH

// same-cycle implication
`define BCPC_ASSERT_IMPLY(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");

// next-cycle implication
`define BCPC_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");

`endif

// ===== hdl/bcpc_pkg.sv =====
package bcpc_pkg;

	localparam int TICK_W  = 16;
	localparam int COUNT_W = 4;
	localparam int CODE_W  = 3;
	localparam int CFG_IDX_W = 1;

	localparam logic [TICK_W-1:0]  LONG_TICKS_RESET  = 16'd1499;
	localparam logic [TICK_W-1:0]  SHORT_TICKS_RESET = 16'd499;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;

	localparam logic [CFG_IDX_W-1:0] REG_LONG_TIMEOUT  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_TIMEOUT = 1'd1;

	localparam logic KIND_EDGE     = 1'b0;
	localparam logic KIND_TICK     = 1'b1;
	localparam logic LEVEL_PRESSED = 1'b0;

	localparam logic [CODE_W-1:0] EV_NONE       = 3'd0;
	localparam logic [CODE_W-1:0] EV_HOLD       = 3'd1;
	localparam logic [CODE_W-1:0] EV_CLICK      = 3'd2;
	localparam logic [CODE_W-1:0] EV_CLICK_HOLD = 3'd3;
	localparam logic [CODE_W-1:0] EV_DOUBLE     = 3'd4;
	localparam logic [CODE_W-1:0] EV_TRIPLE     = 3'd5;

	typedef struct packed {
		logic kind;
		logic level;
	} bcpc_item_t;

	typedef struct packed {
		logic              fire;
		logic [CODE_W-1:0] code;
	} bcpc_result_t;

	function automatic logic [CODE_W-1:0] classify(
		input logic [COUNT_W-1:0] presses,
		input logic [COUNT_W-1:0] releases
	);
		logic [CODE_W-1:0] code;
		code = EV_NONE;
		if (presses == 4'd1 && releases == 4'd0) code = EV_HOLD;
		if (presses == 4'd1 && releases == 4'd1) code = EV_CLICK;
		if (presses == 4'd2 && releases == 4'd1) code = EV_CLICK_HOLD;
		if (presses == 4'd2 && releases == 4'd2) code = EV_DOUBLE;
		if (presses == 4'd3 && releases == 4'd3) code = EV_TRIPLE;
		return code;
	endfunction

	function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
		return (v == COUNT_MAX) ? COUNT_MAX : v + 4'd1;
	endfunction

endpackage

// ===== hdl/bcpc_tracker.sv =====
module bcpc_tracker
	import bcpc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  bcpc_item_t           item,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TICK_W-1:0]    cfg_data,
	output bcpc_result_t         result
);

	logic [TICK_W-1:0]  long_ticks_q;
	logic [TICK_W-1:0]  short_ticks_q;
	logic [COUNT_W-1:0] press_q;
	logic [COUNT_W-1:0] release_q;
	logic               collecting_q;
	logic [TICK_W-1:0]  remaining_q;

	logic [COUNT_W-1:0] press_d;
	logic [COUNT_W-1:0] release_d;
	logic               collecting_d;
	logic [TICK_W-1:0]  remaining_d;
	logic               fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_ticks_q  <= LONG_TICKS_RESET;
			short_ticks_q <= SHORT_TICKS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LONG_TIMEOUT:  long_ticks_q  <= cfg_data;
				REG_SHORT_TIMEOUT: short_ticks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		press_d      = press_q;
		release_d    = release_q;
		collecting_d = collecting_q;
		remaining_d  = remaining_q;
		fire         = 1'b0;
		if (item.kind == KIND_EDGE) begin
			if (item.level == LEVEL_PRESSED) begin
				press_d = sat_inc(press_q);
			end
			if (press_d == '0) begin
				// release with no press counted
				release_d = '0;
			end else begin
				if (item.level != LEVEL_PRESSED) begin
					release_d = sat_inc(release_q);
				end
				collecting_d = 1'b1;
				remaining_d  = collecting_q ? short_ticks_q : long_ticks_q;
			end
		end else if (collecting_q) begin
			if (remaining_q != '0) begin
				remaining_d = remaining_q - 16'd1;
			end else begin
				fire         = 1'b1;
				press_d      = '0;
				release_d    = '0;
				collecting_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_q      <= '0;
			release_q    <= '0;
			collecting_q <= 1'b0;
			remaining_q  <= '0;
		end else if (step) begin
			press_q      <= press_d;
			release_q    <= release_d;
			collecting_q <= collecting_d;
			remaining_q  <= remaining_d;
		end
	end

	assign result.fire = fire;
	assign result.code = classify(press_q, release_q);

endmodule

// ===== hdl/button_click_pattern_classifier_core.sv =====
// Multi-click button classifier. Each input transfer is either a pin edge (tuser 0, level in
// tdata bit 0, 0 pressed) or a timer tick (tuser 1). Presses and releases are counted and,
// once the long or short timeout has run out on ticks, one event code is sent out (0 none,
// 1 hold, 2 click, 3 click-hold, 4 double, 5 triple). One transfer is taken every cycle; an
// item is registered on input and its result is registered on output. Input stalls only
// while a code waits on the output.
module button_click_pattern_classifier_core
	import bcpc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,   // [0] level, [7:1] zero
	input  logic [0:0]           s_tuser,   // [0] kind
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [7:0]           m_tdata,   // [2:0] event_code, [7:3] zero
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TICK_W-1:0]    cfg_data
);

	logic              valid_s1;
	bcpc_item_t        item_s1;
	logic              out_valid_q;
	logic [CODE_W-1:0] out_code_q;
	logic              advance;
	bcpc_result_t      result;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.kind  <= s_tuser[0];
			item_s1.level <= s_tdata[0];
		end
	end

	bcpc_tracker u_tracker (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.item      (item_s1),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && result.fire) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && result.fire) begin
			out_code_q <= result.code;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, out_code_q};

endmodule

// ===== hdl/bcpc_checker.sv =====
`include "button_click_pattern_classifier_core_defines.svh"

module bcpc_checker
	import bcpc_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [7:0]           m_tdata
);

	`BCPC_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`BCPC_ASSERT_IMPLY(a_in_stall_cause, clk, arst_n, !s_tready, m_tvalid && !m_tready)
	`BCPC_ASSERT_IMPLY(a_code_range, clk, arst_n, m_tvalid, m_tdata[2:0] <= EV_TRIPLE)
	`BCPC_ASSERT_IMPLY(a_code_pad, clk, arst_n, m_tvalid, m_tdata[7:3] == 5'd0)

endmodule

bind button_click_pattern_classifier_core bcpc_checker u_bcpc_checker (.*);

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import bcpc_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int SETTLE_CYCLES = 8;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata = 8'd0;    // [0] level, [7:1] zero
	logic [0:0]           s_tuser = 1'b0;    // [0] kind
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [7:0]           m_tdata;           // [2:0] event_code, [7:3] zero
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [TICK_W-1:0]    cfg_data = '0;

	button_click_pattern_classifier_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	bcpc_item_t        stim_q[$];
	logic [CODE_W-1:0] code_q[$];

	// shadow of the block
	logic [TICK_W-1:0]  long_ld = LONG_TICKS_RESET;
	logic [TICK_W-1:0]  short_ld = SHORT_TICKS_RESET;
	logic [COUNT_W-1:0] press_cnt = '0;
	logic [COUNT_W-1:0] rel_cnt = '0;
	logic               collecting = 1'b0;
	logic [TICK_W-1:0]  ticks_left = '0;

	int  mismatch_count = 0;
	int  cycle_cnt = 0;
	int  tx_gap = 0;
	int  rx_wait = 3;
	bit  tx_gapless = 1'b0;
	bit  rx_gapless = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int draw_gap(input bit gapless);
		return gapless ? 0 : $urandom_range(0, 6);
	endfunction

	function automatic logic [CODE_W-1:0] classify_gesture(
		input logic [COUNT_W-1:0] presses,
		input logic [COUNT_W-1:0] releases
	);
		logic [CODE_W-1:0] code;
		code = EV_NONE;
		case ({presses, releases})
			{4'd1, 4'd0}: code = EV_HOLD;
			{4'd1, 4'd1}: code = EV_CLICK;
			{4'd2, 4'd1}: code = EV_CLICK_HOLD;
			{4'd2, 4'd2}: code = EV_DOUBLE;
			{4'd3, 4'd3}: code = EV_TRIPLE;
			default: code = EV_NONE;
		endcase
		return code;
	endfunction

	function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] v);
		return (v == COUNT_MAX) ? COUNT_MAX : v + 1'b1;
	endfunction

	task track_button(input logic kind, input logic level);
		if (kind != KIND_TICK) begin
			if (level == LEVEL_PRESSED)
				press_cnt = bump(press_cnt);
			if (press_cnt == '0) begin
				rel_cnt = '0;
			end else begin
				if (level != LEVEL_PRESSED)
					rel_cnt = bump(rel_cnt);
				ticks_left = collecting ? short_ld : long_ld;
				collecting = 1'b1;
			end
		end else if (collecting) begin
			if (ticks_left != '0) begin
				ticks_left = ticks_left - 1'b1;
			end else begin
				code_q.push_back(classify_gesture(press_cnt, rel_cnt));
				press_cnt = '0;
				rel_cnt = '0;
				collecting = 1'b0;
			end
		end
	endtask

	task report_mismatch(input string msg);
		if (mismatch_count < 100)
			$display("mismatch at cycle %0d: %s", cycle_cnt, msg);
		mismatch_count++;
	endtask

	// input side
	always @(posedge clk) begin
		bcpc_item_t nxt;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				track_button(s_tuser[0], s_tdata[0]);
			if (s_tready || !s_tvalid) begin
				if (tx_gap != 0) begin
					tx_gap <= tx_gap - 1;
					s_tvalid <= 1'b0;
				end else if (stim_q.size() != 0) begin
					nxt = stim_q.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= nxt.kind;
					s_tdata <= {7'd0, nxt.level};
					tx_gap <= draw_gap(tx_gapless);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// output side
	always @(posedge clk) begin
		int w;
		logic [CODE_W-1:0] want;
		if (arst_n) begin
			w = rx_wait;
			if (m_tvalid && m_tready) begin
				if (code_q.size() == 0) begin
					report_mismatch($sformatf("unexpected code %0d", m_tdata[CODE_W-1:0]));
				end else begin
					want = code_q.pop_front();
					if (m_tdata[CODE_W-1:0] !== want)
						report_mismatch($sformatf("code %0d, wanted %0d",
							m_tdata[CODE_W-1:0], want));
				end
				if (m_tdata[7:CODE_W] !== '0)
					report_mismatch($sformatf("padding bits %0h", m_tdata[7:CODE_W]));
				w = draw_gap(rx_gapless);
			end
			if (w != 0) begin
				m_tready <= 1'b0;
				rx_wait <= w - 1;
			end else begin
				m_tready <= 1'b1;
				rx_wait <= 0;
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task add_item(input logic kind, input logic level);
		bcpc_item_t it;
		it.kind = kind;
		it.level = level;
		stim_q.push_back(it);
	endtask

	task add_ticks(input int n);
		for (int i = 0; i < n; i++)
			add_item(KIND_TICK, 1'($urandom_range(0, 1)));
	endtask

	task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_LONG_TIMEOUT)
			long_ld = val;
		else
			short_ld = val;
	endtask

	// wait until every queued item has gone in and every code has come out
	task settle();
		while (stim_q.size() != 0 || s_tvalid || code_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic int edge_gap();
		if ($urandom_range(0, 7) == 0)
			return $urandom_range(0, int'(short_ld) + 2);
		return $urandom_range(0, int'(short_ld));
	endfunction

	function automatic logic pick_level(input logic nominal);
		return ($urandom_range(0, 9) == 0) ? 1'($urandom_range(0, 1)) : nominal;
	endfunction

	task queue_gesture();
		int n;
		int presses;
		int longest;
		if ($urandom_range(0, 5) == 0) begin
			n = $urandom_range(1, 4);
			for (int i = 0; i < n; i++)
				add_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		end
		presses = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 18) : $urandom_range(1, 4);
		for (int i = 0; i < presses; i++) begin
			add_item(KIND_EDGE, pick_level(LEVEL_PRESSED));
			add_ticks(edge_gap());
			if (i != presses - 1 || $urandom_range(0, 3) != 0) begin
				add_item(KIND_EDGE, pick_level(~LEVEL_PRESSED));
				add_ticks(edge_gap());
			end
		end
		longest = (long_ld > short_ld) ? int'(long_ld) : int'(short_ld);
		add_ticks(longest + 1 + $urandom_range(0, 3));
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset timeouts: tick and release while waiting, then a click
		add_item(KIND_TICK, ~LEVEL_PRESSED);
		add_item(KIND_EDGE, ~LEVEL_PRESSED);
		add_item(KIND_TICK, LEVEL_PRESSED);
		add_item(KIND_EDGE, LEVEL_PRESSED);
		add_item(KIND_EDGE, ~LEVEL_PRESSED);
		add_ticks(520);
		settle();

		// zero timeouts: every gesture code in turn
		write_reg(REG_LONG_TIMEOUT, '0);
		write_reg(REG_SHORT_TIMEOUT, '0);
		@(negedge clk);
		add_item(KIND_TICK, LEVEL_PRESSED);
		add_item(KIND_EDGE, ~LEVEL_PRESSED);
		add_item(KIND_TICK, ~LEVEL_PRESSED);
		for (int g = 1; g <= 5; g++) begin
			for (int e = 0; e < g + (g == 5 ? 1 : 0); e++)
				add_item(KIND_EDGE, e[0] ? ~LEVEL_PRESSED : LEVEL_PRESSED);
			add_item(KIND_TICK, 1'($urandom_range(0, 1)));
		end
		settle();

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin
					write_reg(REG_LONG_TIMEOUT, 16'd2);
					write_reg(REG_SHORT_TIMEOUT, 16'd1);
				end
				1: begin
					write_reg(REG_LONG_TIMEOUT, 16'd1);
					write_reg(REG_SHORT_TIMEOUT, 16'd4);
				end
				2: begin
					write_reg(REG_LONG_TIMEOUT, '0);
					write_reg(REG_SHORT_TIMEOUT, '0);
				end
				3: begin
					write_reg(REG_LONG_TIMEOUT, 16'd5);
					write_reg(REG_SHORT_TIMEOUT, '0);
				end
				default: begin
					write_reg(REG_LONG_TIMEOUT, 16'($urandom_range(0, 8)));
					write_reg(REG_SHORT_TIMEOUT, 16'($urandom_range(0, 8)));
				end
			endcase
			@(negedge clk);
			tx_gapless = ($urandom_range(0, 3) == 0);
			rx_gapless = ($urandom_range(0, 3) == 0);
			while (stim_q.size() < 200)
				queue_gesture();
			settle();
		end

		// full-width timeouts, no idling: the gesture must stay open
		write_reg(REG_LONG_TIMEOUT, 16'hffff);
		write_reg(REG_SHORT_TIMEOUT, 16'hffff);
		@(negedge clk);
		tx_gapless = 1'b1;
		rx_gapless = 1'b1;
		add_item(KIND_EDGE, LEVEL_PRESSED);
		add_ticks(10);
		add_item(KIND_EDGE, ~LEVEL_PRESSED);
		add_ticks(20);
		settle();

		repeat (20) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/bcpc_pkg.sv
hdl/bcpc_tracker.sv
hdl/button_click_pattern_classifier_core.sv
hdl/bcpc_checker.sv
dv/testbench.sv
